/* sv/rca_pkg.sv */
package rca_pkg;

   typedef enum logic [0:0] {
      ACT_PUSH  = 1'b0,
      ACT_CLEAR = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_NEXT,
      BK_SEND
   } back_state_type;

endpackage

/* sv/running_covariance_accumulator.sv */
// Running covariance accumulator. Each request either pushes a signed (x, y)
// pair or clears the count and all sums; every request produces exactly one
// response carrying the count, the running sums, the population variances of
// x and y and the covariance, each statistic as
// floor(2^FRAC_BITS * (n*Sab - Sa*Sb) / (n*n)) with variances clamped at zero.
// A push at full count is ignored and flagged. The front end registers the
// updated sums and hands them over through a one-entry queue; the back end
// computes the three statistics one after another on a shared restoring
// divider that yields one quotient bit per cycle. The back end takes new sums
// only when idle, so one further request can wait in the queue meanwhile.
module running_covariance_accumulator
   import rca_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic signed [SAMPLE_BITS-1:0] req_x_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_y_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic        [15:0]            rsp_sample_count,
   output logic signed [31:0]            rsp_sum_x,
   output logic signed [31:0]            rsp_sum_y,
   output logic        [45:0]            rsp_sum_xx,
   output logic        [45:0]            rsp_sum_yy,
   output logic signed [46:0]            rsp_sum_xy,
   output logic        [38:0]            rsp_variance_x,
   output logic        [38:0]            rsp_variance_y,
   output logic signed [39:0]            rsp_covariance,
   output logic                          rsp_count_full
);

   // Internal sums are sized so they never wrap.
   localparam int SX_BITS  = SAMPLE_BITS + COUNT_BITS;
   localparam int SXX_BITS = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int SXY_BITS = 2 * SAMPLE_BITS + COUNT_BITS;

   logic                         q_valid, q_stall, q_full;
   logic        [COUNT_BITS-1:0] q_count;
   logic signed [SX_BITS-1:0]    q_sx, q_sy;
   logic        [SXX_BITS-1:0]   q_sxx, q_syy;
   logic signed [SXY_BITS-1:0]   q_sxy;

   rca_front #(
      .SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS),
      .SX_BITS(SX_BITS), .SXX_BITS(SXX_BITS), .SXY_BITS(SXY_BITS)
   ) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_action,
      .req_x_sample, .req_y_sample,
      .q_valid, .q_stall, .q_count, .q_sx, .q_sy, .q_sxx, .q_syy, .q_sxy, .q_full
   );

   rca_back #(
      .COUNT_BITS(COUNT_BITS), .SX_BITS(SX_BITS), .SXX_BITS(SXX_BITS),
      .SXY_BITS(SXY_BITS), .FRAC_BITS(FRAC_BITS), .VAR_BITS(39), .COV_BITS(40)
   ) u_back (
      .clock, .reset,
      .q_valid, .q_stall, .q_count, .q_sx, .q_sy, .q_sxx, .q_syy, .q_sxy, .q_full,
      .rsp_valid, .rsp_stall, .rsp_sample_count, .rsp_sum_x, .rsp_sum_y,
      .rsp_sum_xx, .rsp_sum_yy, .rsp_sum_xy, .rsp_variance_x, .rsp_variance_y,
      .rsp_covariance, .rsp_count_full
   );

endmodule

/* sv/rca_front.sv */
module rca_front
   import rca_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16,
   parameter int SX_BITS     = 32,
   parameter int SXX_BITS    = 46,
   parameter int SXY_BITS    = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic signed [SAMPLE_BITS-1:0] req_x_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_y_sample,
   output logic                         q_valid,
   input  logic                         q_stall,
   output logic        [COUNT_BITS-1:0] q_count,
   output logic signed [SX_BITS-1:0]    q_sx,
   output logic signed [SX_BITS-1:0]    q_sy,
   output logic        [SXX_BITS-1:0]   q_sxx,
   output logic        [SXX_BITS-1:0]   q_syy,
   output logic signed [SXY_BITS-1:0]   q_sxy,
   output logic                         q_full
);

   logic        [COUNT_BITS-1:0] count_ff, count_in;
   logic signed [SX_BITS-1:0]    sx_ff, sx_in, sy_ff, sy_in;
   logic        [SXX_BITS-1:0]   sxx_ff, sxx_in, syy_ff, syy_in;
   logic signed [SXY_BITS-1:0]   sxy_ff, sxy_in;
   logic                         full_ff, full_in;
   logic                         pend_ff, pend_in;
   logic signed [2*SAMPLE_BITS-1:0] pxx, pyy, pxy;
   logic                         take;

   // One slot: the updated sums wait here until the back end takes them.
   assign req_stall = pend_ff;
   assign take      = req_valid && !req_stall;

   assign pxx = req_x_sample * req_x_sample;
   assign pyy = req_y_sample * req_y_sample;
   assign pxy = req_x_sample * req_y_sample;

   always_comb begin
      count_in = count_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sxx_in   = sxx_ff;
      syy_in   = syy_ff;
      sxy_in   = sxy_ff;
      full_in  = full_ff;
      pend_in  = pend_ff && q_stall;
      if (take) begin
         pend_in = 1'b1;
         full_in = 1'b0;
         if (req_action == ACT_CLEAR) begin
            count_in = '0;
            sx_in    = '0;
            sy_in    = '0;
            sxx_in   = '0;
            syy_in   = '0;
            sxy_in   = '0;
         end else if (&count_ff) begin
            full_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
            sx_in    = sx_ff + SX_BITS'(req_x_sample);
            sy_in    = sy_ff + SX_BITS'(req_y_sample);
            sxx_in   = sxx_ff + SXX_BITS'(unsigned'(pxx));
            syy_in   = syy_ff + SXX_BITS'(unsigned'(pyy));
            sxy_in   = sxy_ff + SXY_BITS'(pxy);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sxx_ff   <= '0;
         syy_ff   <= '0;
         sxy_ff   <= '0;
         full_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sxx_ff   <= sxx_in;
         syy_ff   <= syy_in;
         sxy_ff   <= sxy_in;
         full_ff  <= full_in;
         pend_ff  <= pend_in;
      end
   end

   assign q_valid = pend_ff;
   assign q_count = count_ff;
   assign q_sx    = sx_ff;
   assign q_sy    = sy_ff;
   assign q_sxx   = sxx_ff;
   assign q_syy   = syy_ff;
   assign q_sxy   = sxy_ff;
   assign q_full  = full_ff;

`ifndef SYNTHESIS
   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      $rose(full_ff) |-> $stable(count_ff))
      else $error("full push changed the count");
   a_no_take_when_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff && q_stall |=> pend_ff)
      else $error("pending sums lost");
   a_full_means_max: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> &count_ff)
      else $error("full flag without maximum count");
`endif

endmodule

/* sv/rca_back.sv */
module rca_back
   import rca_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int SX_BITS    = 32,
   parameter int SXX_BITS   = 46,
   parameter int SXY_BITS   = 48,
   parameter int FRAC_BITS  = 8,
   parameter int VAR_BITS   = 39,
   parameter int COV_BITS   = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_stall,
   input  logic        [COUNT_BITS-1:0] q_count,
   input  logic signed [SX_BITS-1:0]    q_sx,
   input  logic signed [SX_BITS-1:0]    q_sy,
   input  logic        [SXX_BITS-1:0]   q_sxx,
   input  logic        [SXX_BITS-1:0]   q_syy,
   input  logic signed [SXY_BITS-1:0]   q_sxy,
   input  logic                         q_full,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic        [15:0]           rsp_sample_count,
   output logic signed [31:0]           rsp_sum_x,
   output logic signed [31:0]           rsp_sum_y,
   output logic        [45:0]           rsp_sum_xx,
   output logic        [45:0]           rsp_sum_yy,
   output logic signed [46:0]           rsp_sum_xy,
   output logic        [VAR_BITS-1:0]   rsp_variance_x,
   output logic        [VAR_BITS-1:0]   rsp_variance_y,
   output logic signed [COV_BITS-1:0]   rsp_covariance,
   output logic                         rsp_count_full
);

   // Numerator width: n*Sab - Sa*Sb, signed.
   localparam int DW = SXY_BITS + COUNT_BITS + 1;
   localparam int NW = 2 * COUNT_BITS;
   localparam int QW = DW + FRAC_BITS;
   localparam int SW = $clog2(QW + 1);

   back_state_type state_ff, state_in;
   logic [1:0]                 sel_ff, sel_in;
   logic        [COUNT_BITS-1:0] n_ff;
   logic signed [SX_BITS-1:0]    sx_ff, sy_ff;
   logic        [SXX_BITS-1:0]   sxx_ff, syy_ff;
   logic signed [SXY_BITS-1:0]   sxy_ff;
   logic                         full_ff;
   logic [NW-1:0]              nn_ff;
   logic signed [DW-1:0]       p1_ff, p2_ff;
   logic                       neg_ff;
   logic [QW-1:0]              num_ff;
   logic [NW:0]                rem_ff;
   logic [SW-1:0]              step_ff;
   logic [QW-1:0]              res_ff [3];
   logic                       out_ff, out_in;

   logic signed [SXY_BITS-1:0] sab;
   logic signed [SX_BITS-1:0]  sa, sb;
   logic signed [2*SX_BITS-1:0] prod;
   logic signed [DW-1:0]       d;
   logic [DW-1:0]              mag;
   logic [NW:0]                trial;
   logic [QW-1:0]              fin;
   logic [QW-1:0]              stat_v;

   always_comb begin
      case (sel_ff)
         2'd0:    begin sab = SXY_BITS'(sxx_ff); sa = sx_ff; sb = sx_ff; end
         2'd1:    begin sab = SXY_BITS'(syy_ff); sa = sy_ff; sb = sy_ff; end
         default: begin sab = sxy_ff;             sa = sx_ff; sb = sy_ff; end
      endcase
   end

   assign prod  = sa * sb;
   assign d     = p1_ff - p2_ff;
   assign mag   = d[DW-1] ? DW'(-d) : DW'(d);
   assign trial = {rem_ff[NW-1:0], num_ff[QW-1]};
   assign fin   = neg_ff ? ((rem_ff != '0) ? ~num_ff : -num_ff) : num_ff;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      out_in   = out_ff && rsp_stall;
      q_stall  = 1'b1;
      case (state_ff)
         BK_IDLE: begin
            q_stall = 1'b0;
            if (q_valid) begin
               state_in = BK_MUL;
               sel_in   = 2'd0;
            end
         end
         BK_MUL:  state_in = BK_DIV;
         BK_DIV:  if (step_ff == SW'(QW)) state_in = BK_NEXT;
         BK_NEXT: begin
            if (sel_ff == 2'd2) begin
               state_in = BK_SEND;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = BK_MUL;
            end
         end
         BK_SEND: if (!out_ff || !rsp_stall) begin
            out_in   = 1'b1;
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         sel_ff   <= 2'd0;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         out_ff   <= out_in;
      end
   end

   always_comb begin
      stat_v = fin;
      if (n_ff == '0) stat_v = '0;
      else if (neg_ff && sel_ff != 2'd2) stat_v = '0;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            n_ff    <= q_count;
            sx_ff   <= q_sx;
            sy_ff   <= q_sy;
            sxx_ff  <= q_sxx;
            syy_ff  <= q_syy;
            sxy_ff  <= q_sxy;
            full_ff <= q_full;
            nn_ff   <= q_count * q_count;
         end
         BK_MUL: begin
            p1_ff   <= DW'(sab) * $signed({1'b0, n_ff});
            p2_ff   <= DW'(prod);
            step_ff <= '0;
            rem_ff  <= '0;
            num_ff  <= '0;
         end
         BK_DIV: begin
            if (step_ff == '0) begin
               neg_ff <= d[DW-1];
               num_ff <= QW'(mag) << FRAC_BITS;
               rem_ff <= '0;
               step_ff <= step_ff + 1'b1;
            end else begin
               // Restoring division, one quotient bit per cycle.
               if (trial >= {1'b0, nn_ff}) begin
                  rem_ff <= trial - {1'b0, nn_ff};
                  num_ff <= {num_ff[QW-2:0], 1'b1};
               end else begin
                  rem_ff <= trial;
                  num_ff <= {num_ff[QW-2:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
            end
         end
         BK_NEXT: res_ff[sel_ff] <= stat_v;
         default: ;
      endcase
   end

   // The first division cycle only loads, so QW steps leave QW-1 bits done;
   // the last bit shifts in on the step that leaves BK_DIV.
   logic [15:0]               c_ff;
   logic signed [31:0]        sx_o, sy_o;
   logic [45:0]               sxx_o, syy_o;
   logic signed [46:0]        sxy_o;
   logic [VAR_BITS-1:0]       vx_o, vy_o;
   logic signed [COV_BITS-1:0] cv_o;
   logic                      full_o;

   always_ff @(posedge clock) begin
      if (state_ff == BK_SEND && state_in == BK_IDLE) begin
         c_ff   <= 16'(n_ff);
         sx_o   <= 32'(sx_ff);
         sy_o   <= 32'(sy_ff);
         sxx_o  <= 46'(sxx_ff);
         syy_o  <= 46'(syy_ff);
         sxy_o  <= 47'(sxy_ff);
         vx_o   <= VAR_BITS'(res_ff[0]);
         vy_o   <= VAR_BITS'(res_ff[1]);
         cv_o   <= COV_BITS'(res_ff[2]);
         full_o <= full_ff;
      end
   end

   assign rsp_valid        = out_ff;
   assign rsp_sample_count = c_ff;
   assign rsp_sum_x        = sx_o;
   assign rsp_sum_y        = sy_o;
   assign rsp_sum_xx       = sxx_o;
   assign rsp_sum_yy       = syy_o;
   assign rsp_sum_xy       = sxy_o;
   assign rsp_variance_x   = vx_o;
   assign rsp_variance_y   = vy_o;
   assign rsp_covariance   = cv_o;
   assign rsp_count_full   = full_o;

`ifndef SYNTHESIS
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      out_ff && rsp_stall |=> out_ff)
      else $error("result dropped while stalled");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      !q_stall |-> state_ff == BK_IDLE)
      else $error("queue taken while busy");
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != BK_IDLE |-> sel_ff != 2'd3)
      else $error("bad statistic select");
`endif

endmodule

/* tb/tb_running_covariance_accumulator.sv */
`timescale 1ns / 100ps

module tb_running_covariance_accumulator;
   import rca_pkg::*;

   localparam int RANDOM_REQUESTS = 1530;
   localparam int CYCLE_LIMIT     = 3000000;
   localparam int DRAIN_CYCLES    = 600;

   // One expected response, at the widths of the response ports.
   typedef struct {
      logic [15:0] sample_count;
      logic [31:0] sum_x;
      logic [31:0] sum_y;
      logic [45:0] sum_xx;
      logic [45:0] sum_yy;
      logic [46:0] sum_xy;
      logic [38:0] variance_x;
      logic [38:0] variance_y;
      logic [39:0] covariance;
      logic        count_full;
   } stats_response;

   // Scoreboard: keeps its own copy of the count and the sums, and a queue of
   // responses still owed by the block, oldest first.
   class covariance_scoreboard;
      bit [15:0] count;
      bit [63:0] acc_x, acc_y, acc_xx, acc_yy, acc_xy;
      stats_response owed[$];
      int errors;

      function new();
         count = 0;
         acc_x = 0;
         acc_y = 0;
         acc_xx = 0;
         acc_yy = 0;
         acc_xy = 0;
         errors = 0;
      endfunction

      // floor(256 * (n*sab - sa*sb) / (n*n)) as a 64-bit two's complement
      // pattern. The magnitude is divided, and a negative result that had a
      // remainder is pushed one further down to round toward minus infinity.
      function bit [63:0] fixed_stat(bit [63:0] sab, bit [63:0] sa, bit [63:0] sb,
                                     bit clamp);
         bit [63:0] n, nn, d, mag, q, r, rs, frac, res;
         bit neg;
         n = {48'd0, count};
         if (n == 0) return 64'd0;
         nn = n * n;
         d = n * sab - sa * sb;
         neg = d[63];
         mag = neg ? (~d + 64'd1) : d;
         q = mag / nn;
         r = mag % nn;
         rs = r << 8;
         frac = rs / nn;
         res = (q << 8) + frac;
         if (!neg) return res;
         if (clamp) return 64'd0;
         if (rs % nn != 0) res = res + 64'd1;
         return ~res + 64'd1;
      endfunction

      // Note an accepted request: update the sums and queue its response.
      function void note_request(action_type act, logic [15:0] xs, logic [15:0] ys);
         stats_response e;
         bit [63:0] x, y;
         bit full;
         full = 0;
         x = {{48{xs[15]}}, xs};
         y = {{48{ys[15]}}, ys};
         if (act == ACT_CLEAR) begin
            count = 0;
            acc_x = 0;
            acc_y = 0;
            acc_xx = 0;
            acc_yy = 0;
            acc_xy = 0;
         end else if (count == 16'hffff) begin
            full = 1;
         end else begin
            acc_x = acc_x + x;
            acc_y = acc_y + y;
            acc_xx = acc_xx + x * x;
            acc_yy = acc_yy + y * y;
            acc_xy = acc_xy + x * y;
            count = count + 16'd1;
         end
         e.sample_count = count;
         e.sum_x = acc_x[31:0];
         e.sum_y = acc_y[31:0];
         e.sum_xx = acc_xx[45:0];
         e.sum_yy = acc_yy[45:0];
         e.sum_xy = acc_xy[46:0];
         e.variance_x = 39'(fixed_stat(acc_xx, acc_x, acc_x, 1'b1));
         e.variance_y = 39'(fixed_stat(acc_yy, acc_y, acc_y, 1'b1));
         e.covariance = 40'(fixed_stat(acc_xy, acc_x, acc_y, 1'b0));
         e.count_full = full;
         owed.push_back(e);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      // Check one accepted response against the oldest owed one.
      function void check_response(stats_response a);
         stats_response e;
         if (owed.size() == 0) begin
            $error("response with nothing owed: count 0x%0h", a.sample_count);
            errors++;
            return;
         end
         e = owed.pop_front();
         compare_field("sample_count", e.sample_count, a.sample_count);
         compare_field("sum_x", e.sum_x, a.sum_x);
         compare_field("sum_y", e.sum_y, a.sum_y);
         compare_field("sum_xx", e.sum_xx, a.sum_xx);
         compare_field("sum_yy", e.sum_yy, a.sum_yy);
         compare_field("sum_xy", e.sum_xy, a.sum_xy);
         compare_field("variance_x", e.variance_x, a.variance_x);
         compare_field("variance_y", e.variance_y, a.variance_y);
         compare_field("covariance", e.covariance, a.covariance);
         compare_field("count_full", e.count_full, a.count_full);
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_action;
   logic signed [15:0] req_x_sample;
   logic signed [15:0] req_y_sample;
   logic               rsp_valid;
   logic               rsp_stall;
   logic        [15:0] rsp_sample_count;
   logic signed [31:0] rsp_sum_x;
   logic signed [31:0] rsp_sum_y;
   logic        [45:0] rsp_sum_xx;
   logic        [45:0] rsp_sum_yy;
   logic signed [46:0] rsp_sum_xy;
   logic        [38:0] rsp_variance_x;
   logic        [38:0] rsp_variance_y;
   logic signed [39:0] rsp_covariance;
   logic               rsp_count_full;

   covariance_scoreboard sb = new();

   // While calm is set neither side idles, giving a long back-to-back stretch.
   bit calm = 0;
   int unsigned cycles = 0;

   running_covariance_accumulator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_count(rsp_sample_count),
      .rsp_sum_x       (rsp_sum_x),
      .rsp_sum_y       (rsp_sum_y),
      .rsp_sum_xx      (rsp_sum_xx),
      .rsp_sum_yy      (rsp_sum_yy),
      .rsp_sum_xy      (rsp_sum_xy),
      .rsp_variance_x  (rsp_variance_x),
      .rsp_variance_y  (rsp_variance_y),
      .rsp_covariance  (rsp_covariance),
      .rsp_count_full  (rsp_count_full)
   );

   // 12 ns clock period.
   initial clock = 0;
   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Watchdog: the slowest correct run is far below this limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_running_covariance_accumulator: errors");
         $finish;
      end
   end

   // The response side stalls now and then, changing only at the falling edge.
   initial rsp_stall = 0;
   always @(negedge clock) begin
      rsp_stall = calm ? 1'b0 : ($urandom_range(99) < 10);
   end

   // Responses are sampled at the rising edge where valid meets no stall.
   always @(posedge clock) begin
      stats_response a;
      if (!reset && rsp_valid && !rsp_stall) begin
         a.sample_count = rsp_sample_count;
         a.sum_x = rsp_sum_x;
         a.sum_y = rsp_sum_y;
         a.sum_xx = rsp_sum_xx;
         a.sum_yy = rsp_sum_yy;
         a.sum_xy = rsp_sum_xy;
         a.variance_x = rsp_variance_x;
         a.variance_y = rsp_variance_y;
         a.covariance = rsp_covariance;
         a.count_full = rsp_count_full;
         sb.check_response(a);
      end
   end

   // Send one request. Called just after a falling edge; it returns just after
   // the falling edge that follows acceptance, with valid still high, so that
   // a back-to-back request only changes the payload.
   task automatic send_request(action_type act, logic [15:0] xs, logic [15:0] ys);
      if (!calm && $urandom_range(99) < 10) begin
         req_valid = 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1;
      req_action = act;
      req_x_sample = xs;
      req_y_sample = ys;
      do @(posedge clock); while (req_stall);
      sb.note_request(act, xs, ys);
      @(negedge clock);
   endtask

   task automatic send_push(logic [15:0] xs, logic [15:0] ys);
      send_request(ACT_PUSH, xs, ys);
   endtask

   // A sample value: mostly spread over the whole range, sometimes small
   // (so that means and variances are easy to follow), sometimes an extreme.
   function automatic logic [15:0] pick_sample();
      int unsigned k;
      k = $urandom_range(99);
      if (k < 60) return 16'($urandom);
      if (k < 85) return 16'($signed($urandom_range(0, 40)) - 20);
      if (k < 92) return 16'h8000;
      return 16'h7fff;
   endfunction

   initial begin
      reset = 1;
      req_valid = 0;
      req_action = ACT_PUSH;
      req_x_sample = 0;
      req_y_sample = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part. A clear on an empty block, then the extremes of both
      // fields so the squares and products reach their largest magnitudes.
      send_request(ACT_CLEAR, 16'h0000, 16'h0000);
      send_push(16'h8000, 16'h8000);
      send_push(16'h7fff, 16'h8000);
      send_push(16'h8000, 16'h7fff);
      send_push(16'h7fff, 16'h7fff);
      send_push(16'hffff, 16'h0000);
      send_push(16'h0000, 16'hffff);
      send_push(16'h5555, 16'haaaa);
      // A clear with a nonzero payload must still zero everything.
      send_request(ACT_CLEAR, 16'h7fff, 16'h8000);
      // One sample alone has zero variance; a second one makes it nonzero.
      send_push(16'd3, 16'hfffd);
      send_push(16'd4, 16'hfffb);
      // Three samples give variances and a negative covariance that do not
      // divide evenly, which exercises rounding toward minus infinity.
      send_push(16'd0, 16'd1);
      send_request(ACT_CLEAR, 16'h0000, 16'h0000);
      send_push(16'd1, 16'hffff);
      send_push(16'd0, 16'd0);
      send_push(16'd0, 16'd0);
      send_push(16'hffff, 16'h0001);
      send_request(ACT_CLEAR, 16'hffff, 16'hffff);
      send_request(ACT_CLEAR, 16'h0000, 16'h0000);

      // Random part: long runs of pushes so the count grows to hundreds,
      // broken by the odd clear.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         calm = (i >= 500 && i < 800);
         // Once, hold the sender off until the block has answered everything.
         if (i == 1000) begin
            req_valid = 0;
            while (sb.owed.size() != 0) @(negedge clock);
         end
         if ($urandom_range(99) < 3)
            send_request(ACT_CLEAR, pick_sample(), pick_sample());
         else
            send_push(pick_sample(), pick_sample());
      end
      calm = 0;
      req_valid = 0;

      while (sb.owed.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (sb.errors == 0)
         $display("tb_running_covariance_accumulator: clean");
      else
         $display("tb_running_covariance_accumulator: errors");
      $finish;
   end

endmodule
